/* sv/kop_pkg.sv */
package kop_pkg;

   // Grammar limits.
   localparam int MAX_STEPS   = 10;
   localparam int MAX_KEY_LEN = 113;
   localparam int FP_BYTES    = 4;

   // Field widths.
   localparam int CHAR_W  = 8;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 7;
   localparam int STEP_W  = 4;
   localparam int ACC_W   = 31;
   localparam int KIND_W  = 2;
   localparam int DATA_W  = 48;

   // Token queue between the front and the back.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   // Special characters of the grammar.
   localparam logic [CHAR_W-1:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [CHAR_W-1:0] CHAR_RBRACKET = 8'h5D;
   localparam logic [CHAR_W-1:0] CHAR_SLASH    = 8'h2F;
   localparam logic [CHAR_W-1:0] CHAR_STAR     = 8'h2A;
   localparam logic [CHAR_W-1:0] CHAR_QUOTE    = 8'h27;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_FINGERPRINT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_STEP        = 2'd1;
   localparam logic [KIND_W-1:0] KIND_KEY         = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SUMMARY     = 2'd3;

   // Class of a punctuation character.
   typedef enum logic [2:0] {
      SYM_OTHER,
      SYM_LBRACKET,
      SYM_RBRACKET,
      SYM_SLASH,
      SYM_STAR,
      SYM_QUOTE
   } sym_type;

   // One classified input word.
   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              eot;
      logic              is_decimal;
      logic              is_hex;
      logic [3:0]        hex_val;
      logic              is_alnum;
      sym_type           sym;
   } token_type;

   // One result word.
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   position;
      logic               ok;
      logic               has_origin;
      logic               wildcard_seen;
      logic [STEP_W-1:0]  step_count;
      logic               last;
   } rsp_type;

endpackage

/* sv/key_origin_expression_parser.sv */
// Channel | Dir | tvalid/tready        | tdata / tuser / tlast
// req     | in  | req_tvalid/tready    | tdata[7:0] in_char; tlast end_of_text
// rsp     | out | rsp_tvalid/tready    | tdata value,position,flags; tuser kind; tlast last
//
// One character is accepted per cycle while the token queue has a free slot. A character
// that yields an element and the end summary sends two result words, the element first.
// A four-entry token queue sits between the classifier and the parser, so input keeps
// flowing while a result waits to be taken.
// Reset is synchronous and active high; it empties the queue and returns the parser to
// the start of an expression.
module key_origin_expression_parser (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,  // [7:0] in_char
   input  logic                       req_tlast,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [kop_pkg::DATA_W-1:0] rsp_tdata,  // [31:0] value, [38:32] position, [39] ok,
                                                  // [40] has_origin, [41] wildcard_seen,
                                                  // [45:42] step_count, [47:46] zero
   output logic [kop_pkg::KIND_W-1:0] rsp_tuser,  // [1:0] kind
   output logic                       rsp_tlast
);

   logic               push;
   logic               fifo_full;
   logic               fifo_not_empty;
   logic               pop;
   kop_pkg::token_type push_token;
   kop_pkg::token_type pop_token;
   kop_pkg::rsp_type   rsp;

   // Classifier.
   kop_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .fifo_full  (fifo_full),
      .push       (push),
      .token      (push_token)
   );

   // Token queue.
   kop_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_token),
      .full      (fifo_full),
      .pop       (pop),
      .not_empty (fifo_not_empty),
      .pop_data  (pop_token)
   );

   // Parser and result register.
   kop_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (fifo_not_empty),
      .tok       (pop_token),
      .tok_pop   (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // Pack the result word.
   assign rsp_tdata = {2'b00, rsp.step_count, rsp.wildcard_seen, rsp.has_origin, rsp.ok,
                       rsp.position, rsp.value};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;

endmodule

/* sv/kop_front.sv */
module kop_front (
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [kop_pkg::CHAR_W-1:0] req_tdata,
   input  logic                       req_tlast,
   input  logic                       fifo_full,
   output logic                       push,
   output kop_pkg::token_type         token
);

   logic [kop_pkg::CHAR_W-1:0] ch;
   logic                       digit;
   logic                       lower_hex;

   assign ch = req_tdata;

   // Take a word whenever the queue has a free slot.
   assign req_tready = !fifo_full;
   assign push       = req_tvalid && !fifo_full;

   // Character classes.
   assign digit     = (ch >= 8'h30) && (ch <= 8'h39);
   assign lower_hex = (ch >= 8'h61) && (ch <= 8'h66);

   always_comb begin
      token            = '0;
      token.ch         = ch;
      token.eot        = req_tlast;
      token.is_decimal = digit;
      token.is_hex     = digit || lower_hex;
      token.hex_val    = digit ? ch[3:0] : (ch[3:0] + 4'd9);
      token.is_alnum   = digit || ((ch >= 8'h61) && (ch <= 8'h7A))
                       || ((ch >= 8'h41) && (ch <= 8'h5A));
      case (ch)
         kop_pkg::CHAR_LBRACKET: token.sym = kop_pkg::SYM_LBRACKET;
         kop_pkg::CHAR_RBRACKET: token.sym = kop_pkg::SYM_RBRACKET;
         kop_pkg::CHAR_SLASH:    token.sym = kop_pkg::SYM_SLASH;
         kop_pkg::CHAR_STAR:     token.sym = kop_pkg::SYM_STAR;
         kop_pkg::CHAR_QUOTE:    token.sym = kop_pkg::SYM_QUOTE;
         default:                token.sym = kop_pkg::SYM_OTHER;
      endcase
   end

endmodule

/* sv/kop_fifo.sv */
module kop_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  kop_pkg::token_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output kop_pkg::token_type pop_data
);

   kop_pkg::token_type                 store_ff [kop_pkg::FIFO_DEPTH];
   logic [kop_pkg::FIFO_PTR_W-1:0]     wr_ptr_ff;
   logic [kop_pkg::FIFO_PTR_W-1:0]     rd_ptr_ff;
   logic [kop_pkg::FIFO_CNT_W-1:0]     count_ff;
   logic                               do_push;
   logic                               do_pop;

   assign full      = (count_ff == kop_pkg::FIFO_CNT_W'(kop_pkg::FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = store_ff[rd_ptr_ff];

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop)      count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (do_push) store_ff[wr_ptr_ff] <= push_data;
   end

endmodule

/* sv/kop_back.sv */
module kop_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               tok_valid,
   input  kop_pkg::token_type tok,
   output logic               tok_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output kop_pkg::rsp_type   rsp
);

   typedef enum logic [2:0] {
      PH_START,
      PH_HEX,
      PH_SEP,
      PH_DIGITS,
      PH_KEY,
      PH_WILD
   } phase_type;

   // Parser state.
   phase_type                       phase_ff,    phase_in;
   logic [3:0]                      high_ff,     high_in;
   logic                            pend_ff,     pend_in;
   logic [kop_pkg::ACC_W-1:0]       acc_ff,      acc_in;
   logic [1:0]                      dcount_ff,   dcount_in;
   logic [kop_pkg::POS_W-1:0]       elem_ff,     elem_in;
   logic [kop_pkg::STEP_W-1:0]      steps_ff,    steps_in;
   logic                            origin_ff,   origin_in;
   logic [1:0]                      wild_ff,     wild_in;
   logic                            err_ff,      err_in;

   // Output register and the slot for a second result.
   logic                            out_valid_ff;
   kop_pkg::rsp_type                out_ff;
   logic                            hold_valid_ff;
   kop_pkg::rsp_type                hold_ff;

   logic                            out_free;
   logic                            elem_valid;
   kop_pkg::rsp_type                elem;
   kop_pkg::rsp_type                summary;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign tok_pop   = tok_valid && !hold_valid_ff && out_free;
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   // Next parser state and the results of the current word.
   always_comb begin
      logic [kop_pkg::POS_W-1:0] key_cnt;
      logic                      key_mode;
      logic [kop_pkg::POS_W-1:0] elem_plus;
      logic [34:0]               nv;
      logic                      ok;

      phase_in   = phase_ff;
      high_in    = high_ff;
      pend_in    = pend_ff;
      acc_in     = acc_ff;
      dcount_in  = dcount_ff;
      elem_in    = elem_ff;
      steps_in   = steps_ff;
      origin_in  = origin_ff;
      wild_in    = wild_ff;
      err_in     = err_ff;
      elem_valid = 1'b0;
      elem       = '0;
      summary    = '0;
      key_cnt    = elem_ff;
      key_mode   = 1'b0;
      elem_plus  = elem_ff + 1'b1;
      nv         = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                 + {31'd0, tok.ch[3:0]};
      ok         = 1'b0;

      if (!err_ff) begin
         case (phase_ff)
            PH_START: begin
               if (tok.sym == kop_pkg::SYM_LBRACKET) begin
                  origin_in = 1'b1;
                  phase_in  = PH_HEX;
                  elem_in   = '0;
                  pend_in   = 1'b0;
               end else begin
                  phase_in = PH_KEY;
                  key_cnt  = '0;
                  key_mode = 1'b1;
               end
            end
            PH_HEX: begin
               if (!tok.is_hex) begin
                  err_in = 1'b1;
               end else if (!pend_ff) begin
                  high_in = tok.hex_val;
                  pend_in = 1'b1;
               end else begin
                  elem_valid     = 1'b1;
                  elem.kind      = kop_pkg::KIND_FINGERPRINT;
                  elem.value     = {24'd0, high_ff, tok.hex_val};
                  elem.position  = elem_ff;
                  elem_in        = elem_plus;
                  pend_in        = 1'b0;
                  if (elem_plus >= kop_pkg::POS_W'(kop_pkg::FP_BYTES)) phase_in = PH_SEP;
               end
            end
            PH_SEP: begin
               if (tok.sym == kop_pkg::SYM_SLASH) begin
                  if (steps_ff >= kop_pkg::STEP_W'(kop_pkg::MAX_STEPS)) begin
                     err_in = 1'b1;
                  end else begin
                     phase_in  = PH_DIGITS;
                     acc_in    = '0;
                     dcount_in = '0;
                  end
               end else if (tok.sym == kop_pkg::SYM_RBRACKET) begin
                  phase_in = PH_KEY;
                  elem_in  = '0;
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_DIGITS: begin
               if (tok.is_decimal) begin
                  if (dcount_ff == 2'd1 && acc_ff == '0) begin
                     err_in = 1'b1;
                  end else if (|nv[34:31]) begin
                     err_in = 1'b1;
                  end else begin
                     acc_in = nv[30:0];
                     if (dcount_ff < 2'd2) dcount_in = dcount_ff + 1'b1;
                  end
               end else if (dcount_ff == 2'd0) begin
                  err_in = 1'b1;
               end else if (tok.sym == kop_pkg::SYM_QUOTE || tok.sym == kop_pkg::SYM_SLASH
                            || tok.sym == kop_pkg::SYM_RBRACKET) begin
                  // The character that ends a step emits it.
                  elem_valid    = 1'b1;
                  elem.kind     = kop_pkg::KIND_STEP;
                  elem.value    = {(tok.sym == kop_pkg::SYM_QUOTE), acc_ff};
                  elem.position = kop_pkg::POS_W'(steps_ff);
                  steps_in      = steps_ff + 1'b1;
                  if (tok.sym == kop_pkg::SYM_QUOTE) begin
                     phase_in = PH_SEP;
                  end else if (tok.sym == kop_pkg::SYM_SLASH) begin
                     if (steps_in >= kop_pkg::STEP_W'(kop_pkg::MAX_STEPS)) begin
                        err_in = 1'b1;
                     end else begin
                        acc_in    = '0;
                        dcount_in = '0;
                     end
                  end else begin
                     phase_in = PH_KEY;
                     elem_in  = '0;
                  end
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_KEY: begin
               key_mode = 1'b1;
            end
            PH_WILD: begin
               if (wild_ff == 2'd1 && tok.sym == kop_pkg::SYM_STAR)      wild_in = 2'd2;
               else if (wild_ff == 2'd2 && tok.sym == kop_pkg::SYM_STAR) wild_in = 2'd3;
               else                                                       err_in  = 1'b1;
            end
            default: begin
               err_in = 1'b1;
            end
         endcase

         // A key character, or the slash that opens the wildcard.
         if (key_mode) begin
            if (tok.is_alnum && key_cnt < kop_pkg::POS_W'(kop_pkg::MAX_KEY_LEN)) begin
               elem_valid    = 1'b1;
               elem.kind     = kop_pkg::KIND_KEY;
               elem.value    = {24'd0, tok.ch};
               elem.position = key_cnt;
               elem_in       = key_cnt + 1'b1;
            end else if (tok.sym == kop_pkg::SYM_SLASH) begin
               wild_in  = 2'd1;
               phase_in = PH_WILD;
               elem_in  = key_cnt;
            end else begin
               err_in  = 1'b1;
               elem_in = key_cnt;
            end
         end
      end

      // End summary from the state after this word.
      ok = !err_in && (phase_in == PH_KEY || (phase_in == PH_WILD && wild_in == 2'd3));
      summary.kind          = kop_pkg::KIND_SUMMARY;
      summary.ok            = ok;
      summary.has_origin    = origin_in;
      summary.wildcard_seen = ok && (phase_in == PH_WILD);
      summary.step_count    = steps_in;
      summary.last          = 1'b1;
   end

   // Parser state and output registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         high_ff       <= '0;
         pend_ff       <= 1'b0;
         acc_ff        <= '0;
         dcount_ff     <= '0;
         elem_ff       <= '0;
         steps_ff      <= '0;
         origin_ff     <= 1'b0;
         wild_ff       <= '0;
         err_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else if (tok_pop) begin
         if (tok.eot) begin
            phase_ff  <= PH_START;
            high_ff   <= '0;
            pend_ff   <= 1'b0;
            acc_ff    <= '0;
            dcount_ff <= '0;
            elem_ff   <= '0;
            steps_ff  <= '0;
            origin_ff <= 1'b0;
            wild_ff   <= '0;
            err_ff    <= 1'b0;
         end else begin
            phase_ff  <= phase_in;
            high_ff   <= high_in;
            pend_ff   <= pend_in;
            acc_ff    <= acc_in;
            dcount_ff <= dcount_in;
            elem_ff   <= elem_in;
            steps_ff  <= steps_in;
            origin_ff <= origin_in;
            wild_ff   <= wild_in;
            err_ff    <= err_in;
         end
         if (elem_valid) begin
            out_ff        <= elem;
            out_valid_ff  <= 1'b1;
            hold_ff       <= summary;
            hold_valid_ff <= tok.eot;
         end else begin
            out_ff       <= summary;
            out_valid_ff <= tok.eot;
         end
      end else if (out_free) begin
         // Move a waiting summary up, or drop the word just taken.
         out_ff        <= hold_ff;
         out_valid_ff  <= hold_valid_ff;
         hold_valid_ff <= 1'b0;
      end
   end

endmodule

/* sv/kop_checker.sv */
module kop_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [kop_pkg::DATA_W-1:0] rsp_tdata,
   input logic [kop_pkg::KIND_W-1:0] rsp_tuser,
   input logic                       rsp_tlast
);

   // The summary word, and only it, carries last.
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == kop_pkg::KIND_SUMMARY)))
      else $error("last does not match the summary kind");

   // Element words leave the summary fields at zero.
   a_elem_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[47:39] == '0)
      else $error("element word carries summary fields");

   // The summary word has zero value and position.
   a_summary_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[38:0] == '0)
      else $error("summary word carries element fields");

   // A wildcard is reported only on an accepted expression.
   a_wild_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && rsp_tdata[41] |-> rsp_tdata[39])
      else $error("wildcard flagged on a rejected expression");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

endmodule

bind key_origin_expression_parser kop_checker u_kop_checker (.*);

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;

   // ASCII bounds used by the parser's character classes.
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;

   localparam int ITEMS_PER_PHASE = 650;
   localparam int HOLD_CYCLES     = 80;
   localparam int HOLD_SPACING    = 700;
   localparam int TAIL_CYCLES     = 20;

   // Idle patterns of the three traffic phases.
   localparam int MODE_RX_SLOW = 0;
   localparam int MODE_TX_SLOW = 1;
   localparam int MODE_FULL    = 2;

   // Parser phases, as the predictor tracks them.
   typedef enum logic [3:0] {
      ST_BEGIN,
      ST_FINGERPRINT,
      ST_AFTER_ITEM,
      ST_NUMBER,
      ST_KEY,
      ST_WILDCARD
   } parse_state_type;

   // Kinds of malformed text the generator can produce.
   typedef enum int {
      FLAW_NONE,
      FLAW_BAD_CHAR,
      FLAW_LEADING_ZERO,
      FLAW_EMPTY_NUMBER,
      FLAW_TOO_LARGE,
      FLAW_TOO_MANY_STEPS,
      FLAW_LONG_KEY,
      FLAW_TRUNCATED,
      FLAW_TAIL_AFTER_WILDCARD,
      FLAW_NOISE
   } flaw_type;

   // One character waiting to be sent.
   typedef struct {
      logic [7:0] ch;
      logic       eot;
      int         mode;
      bit         drain_first;
   } char_item_type;

   logic                        clock;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [7:0]                  req_tdata  = 8'h00;
   logic                        req_tlast  = 1'b0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [kop_pkg::DATA_W-1:0]  rsp_tdata;
   logic [kop_pkg::KIND_W-1:0]  rsp_tuser;
   logic                        rsp_tlast;

   char_item_type               char_q[$];
   kop_pkg::rsp_type            element_q[$];
   logic [7:0]                  text_buf[$];
   int                          fill_mode   = MODE_RX_SLOW;
   bit                          drain_next  = 1'b0;
   int                          cur_mode    = MODE_RX_SLOW;
   bit                          req_fire    = 1'b0;
   int                          accepted_count = 0;
   int                          fail_count  = 0;

   // Predictor state.
   parse_state_type             p_state;
   logic [3:0]                  p_hi_nibble;
   logic                        p_half;
   logic [kop_pkg::ACC_W-1:0]   p_acc;
   logic [1:0]                  p_digits;
   logic [kop_pkg::POS_W-1:0]   p_index;
   logic [kop_pkg::STEP_W-1:0]  p_steps;
   logic                        p_origin;
   logic [1:0]                  p_wild;
   logic                        p_error;

   key_origin_expression_parser i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit is_decimal(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic bit is_alnum(input logic [7:0] c);
      return is_decimal(c) || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
             (c >= CH_LOWER_A && c <= CH_LOWER_Z);
   endfunction

   // ---------------------------------------------------------------- predictor

   task automatic clear_parser();
      p_state     = ST_BEGIN;
      p_hi_nibble = '0;
      p_half      = 1'b0;
      p_acc       = '0;
      p_digits    = '0;
      p_index     = '0;
      p_steps     = '0;
      p_origin    = 1'b0;
      p_wild      = '0;
      p_error     = 1'b0;
   endtask

   task automatic push_element(input logic [kop_pkg::KIND_W-1:0] kind,
                               input logic [kop_pkg::VALUE_W-1:0] value,
                               input logic [kop_pkg::POS_W-1:0] pos);
      kop_pkg::rsp_type w;
      w          = '0;
      w.kind     = kind;
      w.value    = value;
      w.position = pos;
      element_q.push_back(w);
   endtask

   task automatic open_key();
      p_state = ST_KEY;
      p_index = '0;
   endtask

   task automatic open_step();
      if (p_steps >= kop_pkg::MAX_STEPS) begin
         p_error = 1'b1;
      end else begin
         p_state  = ST_NUMBER;
         p_acc    = '0;
         p_digits = '0;
      end
   endtask

   task automatic close_step(input logic [kop_pkg::VALUE_W-1:0] value);
      push_element(kop_pkg::KIND_STEP, value, {3'b000, p_steps});
      p_steps = p_steps + 1'b1;
   endtask

   task automatic key_symbol(input logic [7:0] c);
      if (is_alnum(c) && p_index < kop_pkg::MAX_KEY_LEN) begin
         push_element(kop_pkg::KIND_KEY, {24'd0, c}, p_index);
         p_index = p_index + 1'b1;
      end else if (c == kop_pkg::CHAR_SLASH) begin
         p_wild  = 2'd1;
         p_state = ST_WILDCARD;
      end else begin
         p_error = 1'b1;
      end
   endtask

   // Advances the parser by one character and queues the words it yields.
   task automatic parse_expression_char(input logic [7:0] c, input logic eot);
      logic [3:0]       nib;
      logic [63:0]      grown;
      kop_pkg::rsp_type w;
      logic             ok;
      if (!p_error) begin
         case (p_state)
            ST_BEGIN: begin
               if (c == kop_pkg::CHAR_LBRACKET) begin
                  p_origin = 1'b1;
                  p_state  = ST_FINGERPRINT;
                  p_index  = '0;
                  p_half   = 1'b0;
               end else begin
                  open_key();
                  key_symbol(c);
               end
            end
            ST_FINGERPRINT: begin
               if (is_decimal(c) || (c >= CH_LOWER_A && c <= CH_LOWER_F)) begin
                  nib = is_decimal(c) ? 4'(c - CH_ZERO) : 4'(c - CH_LOWER_A + 8'd10);
                  if (!p_half) begin
                     p_hi_nibble = nib;
                     p_half      = 1'b1;
                  end else begin
                     push_element(kop_pkg::KIND_FINGERPRINT, {24'd0, p_hi_nibble, nib},
                                  p_index);
                     p_index = p_index + 1'b1;
                     p_half  = 1'b0;
                     if (p_index >= kop_pkg::FP_BYTES) p_state = ST_AFTER_ITEM;
                  end
               end else begin
                  p_error = 1'b1;
               end
            end
            ST_AFTER_ITEM: begin
               if (c == kop_pkg::CHAR_SLASH) open_step();
               else if (c == kop_pkg::CHAR_RBRACKET) open_key();
               else p_error = 1'b1;
            end
            ST_NUMBER: begin
               if (is_decimal(c)) begin
                  grown = 64'(p_acc) * 64'd10 + 64'(c - CH_ZERO);
                  if (p_digits == 2'd1 && p_acc == '0) begin
                     p_error = 1'b1;
                  end else if (grown >= 64'h8000_0000) begin
                     p_error = 1'b1;
                  end else begin
                     p_acc = grown[kop_pkg::ACC_W-1:0];
                     if (p_digits < 2'd2) p_digits = p_digits + 1'b1;
                  end
               end else if (p_digits == 2'd0) begin
                  p_error = 1'b1;
               end else if (c == kop_pkg::CHAR_QUOTE) begin
                  close_step({1'b1, p_acc});
                  p_state = ST_AFTER_ITEM;
               end else if (c == kop_pkg::CHAR_SLASH) begin
                  close_step({1'b0, p_acc});
                  open_step();
               end else if (c == kop_pkg::CHAR_RBRACKET) begin
                  close_step({1'b0, p_acc});
                  open_key();
               end else begin
                  p_error = 1'b1;
               end
            end
            ST_KEY: key_symbol(c);
            ST_WILDCARD: begin
               if (p_wild == 2'd1 && c == kop_pkg::CHAR_STAR) p_wild = 2'd2;
               else if (p_wild == 2'd2 && c == kop_pkg::CHAR_STAR) p_wild = 2'd3;
               else p_error = 1'b1;
            end
            default: p_error = 1'b1;
         endcase
      end

      // The last character closes the expression with a summary word.
      if (eot) begin
         ok = !p_error && (p_state == ST_KEY || (p_state == ST_WILDCARD && p_wild == 2'd3));
         w               = '0;
         w.kind          = kop_pkg::KIND_SUMMARY;
         w.ok            = ok;
         w.has_origin    = p_origin;
         w.wildcard_seen = ok && p_state == ST_WILDCARD;
         w.step_count    = p_steps;
         w.last          = 1'b1;
         element_q.push_back(w);
         clear_parser();
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic logic [7:0] random_alnum();
      int r;
      r = $urandom_range(0, 61);
      if (r < 10) return CH_ZERO + 8'(r);
      if (r < 36) return CH_UPPER_A + 8'(r - 10);
      return CH_LOWER_A + 8'(r - 36);
   endfunction

   function automatic logic [7:0] hex_char(input int nib);
      return (nib < 10) ? CH_ZERO + 8'(nib) : CH_LOWER_A + 8'(nib - 10);
   endfunction

   task automatic put_number(input longint unsigned v);
      logic [7:0] digs[$];
      do begin
         digs.push_front(CH_ZERO + 8'(v % 10));
         v = v / 10;
      end while (v != 0);
      foreach (digs[i]) text_buf.push_back(digs[i]);
   endtask

   function automatic longint unsigned random_step_value();
      case ($urandom_range(0, 4))
         0:       return 0;
         1:       return $urandom_range(1, 99);
         2:       return $urandom_range(100, 99999);
         3:       return 64'h7FFF_FFFF;
         default: return $urandom & 32'h7FFF_FFFF;
      endcase
   endfunction

   // Moves the text buffer into the send queue, end of text on its last character.
   task automatic flush_text();
      char_item_type it;
      foreach (text_buf[i]) begin
         it.ch          = text_buf[i];
         it.eot         = (i == text_buf.size() - 1);
         it.mode        = fill_mode;
         it.drain_first = (i == 0) && drain_next;
         char_q.push_back(it);
      end
      text_buf.delete();
      drain_next = 1'b0;
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
      flush_text();
   endtask

   // Builds one expression, mostly well formed, sometimes with a single flaw.
   task automatic random_expression();
      flaw_type flaw;
      bit       with_origin;
      bit       with_wild;
      int       nsteps;
      int       bad_step;
      int       key_len;
      int       cut;
      if ($urandom_range(0, 9) < 6) flaw = FLAW_NONE;
      else flaw = flaw_type'($urandom_range(FLAW_BAD_CHAR, FLAW_NOISE));
      if ($urandom_range(0, 19) == 0) drain_next = 1'b1;

      if (flaw == FLAW_NOISE) begin
         repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
         flush_text();
         return;
      end

      with_origin = flaw inside {FLAW_LEADING_ZERO, FLAW_EMPTY_NUMBER, FLAW_TOO_LARGE,
                                 FLAW_TOO_MANY_STEPS} || $urandom_range(0, 9) < 7;
      with_wild   = flaw == FLAW_TAIL_AFTER_WILDCARD || $urandom_range(0, 9) < 3;

      // Origin: bracket, fingerprint and a run of derivation steps.
      if (with_origin) begin
         text_buf.push_back(kop_pkg::CHAR_LBRACKET);
         repeat (2 * kop_pkg::FP_BYTES) text_buf.push_back(hex_char($urandom_range(0, 15)));
         if (flaw == FLAW_TOO_MANY_STEPS) nsteps = kop_pkg::MAX_STEPS + 1;
         else if ($urandom_range(0, 7) == 0) nsteps = kop_pkg::MAX_STEPS;
         else nsteps = $urandom_range(0, 3);
         if (nsteps == 0 && flaw != FLAW_NONE) nsteps = 1;
         bad_step = (nsteps > 0) ? $urandom_range(0, nsteps - 1) : 0;
         for (int i = 0; i < nsteps; i++) begin
            text_buf.push_back(kop_pkg::CHAR_SLASH);
            if (i == bad_step && flaw == FLAW_LEADING_ZERO) begin
               text_buf.push_back(CH_ZERO);
               text_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end else if (i == bad_step && flaw == FLAW_TOO_LARGE) begin
               put_number(64'h8000_0000 + $urandom_range(0, 1_000_000_000));
            end else if (!(i == bad_step && flaw == FLAW_EMPTY_NUMBER)) begin
               put_number(random_step_value());
            end
            if ($urandom_range(0, 1)) text_buf.push_back(kop_pkg::CHAR_QUOTE);
         end
         text_buf.push_back(kop_pkg::CHAR_RBRACKET);
      end

      // Key characters, now and then at or past the length limit.
      if (flaw == FLAW_LONG_KEY) key_len = kop_pkg::MAX_KEY_LEN + $urandom_range(1, 3);
      else if ($urandom_range(0, 19) == 0) key_len = kop_pkg::MAX_KEY_LEN;
      else key_len = $urandom_range(0, 10);
      repeat (key_len) text_buf.push_back(random_alnum());

      if (with_wild) begin
         text_buf.push_back(kop_pkg::CHAR_SLASH);
         text_buf.push_back(kop_pkg::CHAR_STAR);
         text_buf.push_back(kop_pkg::CHAR_STAR);
         if (flaw == FLAW_TAIL_AFTER_WILDCARD)
            text_buf.push_back(8'($urandom_range(0, 255)));
      end
      if (text_buf.size() == 0) text_buf.push_back(random_alnum());

      if (flaw == FLAW_TRUNCATED && text_buf.size() > 1) begin
         cut = $urandom_range(1, text_buf.size() - 1);
         repeat (cut) void'(text_buf.pop_back());
      end else if (flaw == FLAW_BAD_CHAR) begin
         text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
      end
      flush_text();
   endtask

   // Fill the send queue, run reset, then wait for the last result.
   initial begin
      clear_parser();

      // Directed words: full grammar with limits, then single-character extremes.
      put_text("[0123abcd/0/2147483647']Zz9/**");
      text_buf.push_back(8'h00);
      flush_text();
      text_buf.push_back(8'hFF);
      flush_text();

      while (char_q.size() < ITEMS_PER_PHASE) random_expression();
      fill_mode  = MODE_TX_SLOW;
      drain_next = 1'b1;
      while (char_q.size() < 2 * ITEMS_PER_PHASE) random_expression();
      fill_mode  = MODE_FULL;
      drain_next = 1'b1;
      while (char_q.size() < 3 * ITEMS_PER_PHASE) random_expression();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (char_q.size() != 0 || req_tvalid) @(posedge clock);
      while (element_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0 && element_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------- driver

   function automatic int sender_gap_pct(input int mode);
      return (mode == MODE_RX_SLOW) ? 11 : (mode == MODE_TX_SLOW) ? 57 : 0;
   endfunction

   function automatic int receiver_gap_pct(input int mode);
      return (mode == MODE_RX_SLOW) ? 57 : (mode == MODE_TX_SLOW) ? 11 : 0;
   endfunction

   // Offer the next character once the current word is gone.
   always @(negedge clock) begin : drive_chars
      char_item_type it;
      logic          offer;
      if (!reset && (!req_tvalid || req_fire)) begin
         offer = 1'b0;
         if (char_q.size() != 0) begin
            it = char_q[0];
            if (!(it.drain_first && element_q.size() != 0) &&
                $urandom_range(0, 99) >= sender_gap_pct(it.mode)) begin
               offer = 1'b1;
               void'(char_q.pop_front());
               req_tdata <= it.ch;
               req_tlast <= it.eot;
               cur_mode  <= it.mode;
            end
         end
         req_tvalid <= offer;
      end
   end

   // Result side: random stalls, plus a long hold-off every so often so the
   // token queue fills up and the input stalls.
   always @(negedge clock) begin : drive_ready
      int hold_left;
      int next_hold_at;
      if (next_hold_at == 0) next_hold_at = 400;
      if (!reset) begin
         if (hold_left == 0 && accepted_count >= next_hold_at) begin
            hold_left    = HOLD_CYCLES;
            next_hold_at = next_hold_at + HOLD_SPACING;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= $urandom_range(0, 99) >= receiver_gap_pct(cur_mode);
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   // Check result words first, then predict from the character taken at the same edge.
   always @(posedge clock) begin : watch
      kop_pkg::rsp_type want;
      req_fire = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (element_q.size() == 0) begin
               $error("result word with nothing expected: tuser 0x%0h tdata 0x%0h",
                      rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               want = element_q.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_tuser));
               check_field("value", want.value, rsp_tdata[31:0]);
               check_field("position", 32'(want.position), 32'(rsp_tdata[38:32]));
               check_field("ok", 32'(want.ok), 32'(rsp_tdata[39]));
               check_field("has_origin", 32'(want.has_origin), 32'(rsp_tdata[40]));
               check_field("wildcard_seen", 32'(want.wildcard_seen), 32'(rsp_tdata[41]));
               check_field("step_count", 32'(want.step_count), 32'(rsp_tdata[45:42]));
               check_field("last", 32'(want.last), 32'(rsp_tlast));
               check_field("padding", 32'd0, 32'(rsp_tdata[47:46]));
            end
         end
         if (req_tvalid && req_tready) begin
            parse_expression_char(req_tdata, req_tlast);
            req_fire       = 1'b1;
            accepted_count = accepted_count + 1;
         end
      end
   end

endmodule
